@@ design/critical_path_scheduler_core_assert.svh @@
// ---------------------------------------------------------------------------
// Critical path scheduler assertion macros
// Shorthand for the concurrent checks at the end of the scheduler core.
// ---------------------------------------------------------------------------
`ifndef CRITICAL_PATH_SCHEDULER_CORE_ASSERT_SVH
`define CRITICAL_PATH_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Scheduler assertion failed.");

// Next-cycle implication.
`define CPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Scheduler assertion failed.");

`endif

@@ design/cps_pkg.sv @@
// ---------------------------------------------------------------------------
// Critical path scheduler package
// Commands, status codes, the link record, the arithmetic unit controls and
// time saturation shared by the scheduler modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cps_pkg;

  localparam int TIME_W = 24;
  localparam int ACC_W  = 27;
  localparam int DEG_W  = 6;
  localparam int IDX_W  = 6;

  localparam logic signed [ACC_W-1:0]  ACC_TMAX = 27'sd8388607;
  localparam logic signed [ACC_W-1:0]  ACC_TMIN = -27'sd8388608;
  localparam logic signed [TIME_W-1:0] TIME_MAX = 24'sh7FFFFF;
  localparam logic signed [TIME_W-1:0] TIME_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_TASK  = 2'd1,
    CMD_LINK  = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TFULL  = 3'd1,
    ST_LFULL  = 3'd2,
    ST_BADIDX = 3'd3,
    ST_SELF   = 3'd4,
    ST_DUP    = 3'd5,
    ST_CYCLE  = 3'd6,
    ST_DISC   = 3'd7
  } status_e;

  typedef struct packed {
    logic [4:0]  pred;
    logic [4:0]  succ;
    logic [1:0]  kind;
    logic [15:0] lag;
  } link_t;

  typedef struct packed {
    logic       fwd;
    logic [1:0] kind;
    logic       any;
  } alu_ctl_t;

  function automatic logic signed [TIME_W-1:0] sat_time(input logic signed [ACC_W-1:0] v);
    logic signed [TIME_W-1:0] r;
    r = TIME_W'(v);
    if (v > ACC_TMAX) begin
      r = TIME_MAX;
    end else if (v < ACC_TMIN) begin
      r = TIME_MIN;
    end
    return r;
  endfunction

endpackage

@@ design/cps_alu.sv @@
// ---------------------------------------------------------------------------
// Critical path scheduler link arithmetic
// Forms the candidate time along one link and compares it with the running
// best value for the forward or the backward pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cps_alu import cps_pkg::*; (
  input  alu_ctl_t                  ctl_i,
  input  logic signed [TIME_W-1:0]  start_i,
  input  logic signed [TIME_W-1:0]  finish_i,
  input  logic        [TIME_W-1:0]  dur_i,
  input  logic        [15:0]        lag_i,
  input  logic signed [ACC_W-1:0]   acc_i,
  output logic signed [ACC_W-1:0]   cand_o,
  output logic                      better_o
);

  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] lag_x;
  logic signed [ACC_W-1:0] dur_x;

  always_comb begin
    lag_x = ACC_W'($signed(lag_i));
    dur_x = ACC_W'(dur_i);
    if (ctl_i.fwd) begin
      base   = ctl_i.kind[0] ? ACC_W'(start_i) : ACC_W'(finish_i);
      cand_o = base + lag_x - (ctl_i.kind[1] ? dur_x : '0);
      better_o = cand_o > acc_i;
    end else begin
      base   = ctl_i.kind[1] ? ACC_W'(finish_i) : ACC_W'(start_i);
      cand_o = base - lag_x + (ctl_i.kind[0] ? dur_x : '0);
      better_o = !ctl_i.any || (cand_o < acc_i);
    end
  end

endmodule

@@ design/critical_path_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// Critical path scheduler core
// Task and link store with cycle rejection, topological sort and forward and
// backward scheduling passes.
// ---------------------------------------------------------------------------
// Usage: commands enter on the in_valid_i / in_ready_o channel and results
// leave on the out_valid_o / out_ready_i channel. Clear, add task and add
// link answer with one item each; compute answers with one row per ordered
// task and a summary row, or with a single disconnected item.
// Add link walks the stored links once per closure pass, at most MAX_TASKS
// passes. Compute walks the link table once per task in the sort and in both
// passes, and the connectivity check adds up to MAX_TASKS walks of the link
// table. All these walks go through the single read port of the link memory.
// One command is worked on at a time; in_ready_o is high only when the
// sequencer is idle. A result register decouples the output, so a stalled
// receiver holds the sequencer only when it has a further item to deliver.
// Reset empties both tables and drops any pending result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "critical_path_scheduler_core_assert.svh"

module critical_path_scheduler_core import cps_pkg::*; #(
  parameter int MAX_TASKS     = 32,
  parameter int MAX_LINKS     = 64,
  parameter int DURATION_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [15:0]               duration_i,
  input  logic [4:0]                pred_index_i,
  input  logic [4:0]                succ_index_i,
  input  logic [1:0]                link_kind_i,
  input  logic signed [15:0]        lag_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [IDX_W-1:0]          entry_index_o,
  output logic signed [TIME_W-1:0]  early_start_o,
  output logic signed [TIME_W-1:0]  early_finish_o,
  output logic signed [TIME_W-1:0]  late_start_o,
  output logic signed [TIME_W-1:0]  late_finish_o,
  output logic                      is_critical_o,
  output logic [22:0]               total_duration_o,
  output logic                      is_summary_o,
  output logic                      last_o
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int LW  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int DW  = DURATION_BITS;
  localparam int NS  = 39;

  typedef enum logic [NS-1:0] {
    S_IDLE     = NS'(1) << 0,
    S_RESP     = NS'(1) << 1,
    S_RCH_RD   = NS'(1) << 2,
    S_RCH_EX   = NS'(1) << 3,
    S_LNK_DONE = NS'(1) << 4,
    S_CON_RD   = NS'(1) << 5,
    S_CON_EX   = NS'(1) << 6,
    S_CON_CHK  = NS'(1) << 7,
    S_DEG_CLR  = NS'(1) << 8,
    S_CNT_RD   = NS'(1) << 9,
    S_CNT_DG   = NS'(1) << 10,
    S_CNT_WR   = NS'(1) << 11,
    S_SRC_RD   = NS'(1) << 12,
    S_SRC_EX   = NS'(1) << 13,
    S_KHN_TOP  = NS'(1) << 14,
    S_KHN_NODE = NS'(1) << 15,
    S_KHN_RD   = NS'(1) << 16,
    S_KHN_EX   = NS'(1) << 17,
    S_KHN_DG   = NS'(1) << 18,
    S_FWD_TOP  = NS'(1) << 19,
    S_FWD_NODE = NS'(1) << 20,
    S_FWD_INIT = NS'(1) << 21,
    S_FWD_RD   = NS'(1) << 22,
    S_FWD_EX   = NS'(1) << 23,
    S_FWD_CAND = NS'(1) << 24,
    S_FWD_WR   = NS'(1) << 25,
    S_FWD_WR2  = NS'(1) << 26,
    S_BWD_TOP  = NS'(1) << 27,
    S_BWD_NODE = NS'(1) << 28,
    S_BWD_INIT = NS'(1) << 29,
    S_BWD_RD   = NS'(1) << 30,
    S_BWD_EX   = NS'(1) << 31,
    S_BWD_CAND = NS'(1) << 32,
    S_BWD_WR   = NS'(1) << 33,
    S_BWD_WR2  = NS'(1) << 34,
    S_ROW_TOP  = NS'(1) << 35,
    S_ROW_NODE = NS'(1) << 36,
    S_ROW_OUT  = NS'(1) << 37,
    S_SUM      = NS'(1) << 38
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]  task_count_q, task_count_d;
  logic [LCW-1:0] link_count_q, link_count_d;
  logic [CW-1:0]  tidx_q, tidx_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]  tidx_m1;
  logic [LCW-1:0] lidx_q, lidx_d;
  logic [TW-1:0]  node_q, node_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [TIME_W-1:0] total_q, total_d;
  logic any_q, any_d, changed_q, changed_d, dup_q, dup_d;
  logic [MAX_TASKS-1:0] visited_q, visited_d;
  logic [4:0]  pred_q, pred_d, succ_q, succ_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] lag_q, lag_d;
  status_e res_status_q, res_status_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;

  link_t                    lnk_mem [MAX_LINKS];
  link_t                    lnk_rd_q;
  logic                     lnk_we, lnk_re;
  logic [DW-1:0]            dur_mem [MAX_TASKS];
  logic [DW-1:0]            dur_rd_q;
  logic                     dur_we, dur_re;
  logic signed [TIME_W-1:0] es_mem [MAX_TASKS];
  logic signed [TIME_W-1:0] ef_mem [MAX_TASKS];
  logic signed [TIME_W-1:0] ls_mem [MAX_TASKS];
  logic signed [TIME_W-1:0] lf_mem [MAX_TASKS];
  logic signed [TIME_W-1:0] es_rd_q, ef_rd_q, ls_rd_q, lf_rd_q;
  logic                     fwd_we, bwd_we, tim_re;
  logic [TW-1:0]            tim_raddr;
  logic signed [TIME_W-1:0] wr_a, wr_b;
  logic [DEG_W-1:0]         deg_mem [MAX_TASKS];
  logic [DEG_W-1:0]         deg_rd_q, deg_wdata;
  logic                     deg_we, deg_re;
  logic [TW-1:0]            deg_waddr, deg_raddr;
  logic [TW-1:0]            topo_mem [MAX_TASKS];
  logic [TW-1:0]            topo_rd_q, topo_wdata;
  logic                     topo_we, topo_re;
  logic [TW-1:0]            topo_waddr, topo_raddr;

  logic out_valid_q, out_free, out_load;
  logic [2:0] out_status_q, out_status_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic signed [TIME_W-1:0] out_es_q, out_ef_q, out_ls_q, out_lf_q;
  logic signed [TIME_W-1:0] out_es_d, out_ef_d, out_ls_d, out_lf_d;
  logic out_crit_q, out_crit_d, out_sum_q, out_sum_d, out_last_q, out_last_d;
  logic [22:0] out_total_q, out_total_d;

  alu_ctl_t alu_ctl;
  logic signed [TIME_W-1:0] alu_start, alu_finish;
  logic signed [ACC_W-1:0] alu_cand;
  logic alu_better;
  logic [TIME_W-1:0] dur_x;
  logic last_link, conn_ok;
  logic signed [TIME_W-1:0] ef_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_link  = (lidx_q == link_count_q - LCW'(1));
  assign tidx_m1    = tidx_q - CW'(1);
  assign dur_x      = TIME_W'(dur_rd_q);
  assign ef_new     = sat_time(acc_q + ACC_W'(dur_x));

  always_comb begin
    conn_ok = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (CW'(i) < task_count_q && !visited_q[i]) begin
        conn_ok = 1'b0;
      end
    end
  end

  assign alu_ctl.fwd  = (state_q == S_FWD_CAND);
  assign alu_ctl.kind = lnk_rd_q.kind;
  assign alu_ctl.any  = any_q;
  assign alu_start    = alu_ctl.fwd ? es_rd_q : ls_rd_q;
  assign alu_finish   = alu_ctl.fwd ? ef_rd_q : lf_rd_q;

  cps_alu u_alu (
    .ctl_i    (alu_ctl),
    .start_i  (alu_start),
    .finish_i (alu_finish),
    .dur_i    (dur_x),
    .lag_i    (lnk_rd_q.lag),
    .acc_i    (acc_q),
    .cand_o   (alu_cand),
    .better_o (alu_better)
  );

  always_comb begin
    logic chg;
    chg = 1'b0;
    state_d = state_q;
    task_count_d = task_count_q;
    link_count_d = link_count_q;
    tidx_d = tidx_q;
    head_d = head_q;
    tail_d = tail_q;
    lidx_d = lidx_q;
    node_d = node_q;
    acc_d = acc_q;
    total_d = total_q;
    any_d = any_q;
    changed_d = changed_q;
    dup_d = dup_q;
    visited_d = visited_q;
    pred_d = pred_q;
    succ_d = succ_q;
    kind_d = kind_q;
    lag_d = lag_q;
    res_status_d = res_status_q;
    res_idx_d = res_idx_q;
    lnk_we = 1'b0;
    lnk_re = 1'b0;
    dur_we = 1'b0;
    dur_re = 1'b0;
    fwd_we = 1'b0;
    bwd_we = 1'b0;
    tim_re = 1'b0;
    tim_raddr = topo_rd_q;
    wr_a = acc_q[TIME_W-1:0];
    wr_b = ef_new;
    deg_we = 1'b0;
    deg_re = 1'b0;
    deg_waddr = TW'(lnk_rd_q.succ);
    deg_raddr = TW'(lnk_rd_q.succ);
    deg_wdata = '0;
    topo_we = 1'b0;
    topo_re = 1'b0;
    topo_waddr = tail_q[TW-1:0];
    topo_raddr = tidx_q[TW-1:0];
    topo_wdata = TW'(lnk_rd_q.succ);
    out_load = 1'b0;
    out_status_d = ST_OK;
    out_idx_d = '0;
    out_es_d = '0;
    out_ef_d = '0;
    out_ls_d = '0;
    out_lf_d = '0;
    out_crit_d = 1'b0;
    out_total_d = '0;
    out_sum_d = 1'b0;
    out_last_d = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pred_d = pred_index_i;
          succ_d = succ_index_i;
          kind_d = link_kind_i;
          lag_d  = lag_i;
          res_status_d = ST_OK;
          res_idx_d = '0;
          state_d = S_RESP;
          unique case (cmd_i)
            CMD_CLEAR: begin
              task_count_d = '0;
              link_count_d = '0;
            end
            CMD_TASK: begin
              if (task_count_q >= CW'(MAX_TASKS)) begin
                res_status_d = ST_TFULL;
              end else begin
                dur_we = 1'b1;
                res_idx_d = IDX_W'(task_count_q);
                task_count_d = task_count_q + CW'(1);
              end
            end
            CMD_LINK: begin
              if (link_count_q >= LCW'(MAX_LINKS)) begin
                res_status_d = ST_LFULL;
              end else if (7'(pred_index_i) >= 7'(task_count_q) ||
                           7'(succ_index_i) >= 7'(task_count_q)) begin
                res_status_d = ST_BADIDX;
              end else if (pred_index_i == succ_index_i) begin
                res_status_d = ST_SELF;
              end else begin
                visited_d = '0;
                visited_d[TW'(succ_index_i)] = 1'b1;
                dup_d = 1'b0;
                changed_d = 1'b0;
                lidx_d = '0;
                state_d = (link_count_q == '0) ? S_LNK_DONE : S_RCH_RD;
              end
            end
            default: begin
              lidx_d = '0;
              tidx_d = '0;
              changed_d = 1'b0;
              visited_d = '0;
              visited_d[0] = 1'b1;
              if (task_count_q <= CW'(1)) begin
                state_d = S_DEG_CLR;
              end else begin
                state_d = (link_count_q == '0) ? S_CON_CHK : S_CON_RD;
              end
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_status_d = res_status_q;
          out_idx_d = res_idx_q;
          state_d = S_IDLE;
        end
      end
      S_RCH_RD: begin
        lnk_re = 1'b1;
        state_d = S_RCH_EX;
      end
      S_RCH_EX: begin
        if (lnk_rd_q.pred == pred_q && lnk_rd_q.succ == succ_q) begin
          dup_d = 1'b1;
        end
        if (visited_q[TW'(lnk_rd_q.pred)] && !visited_q[TW'(lnk_rd_q.succ)]) begin
          visited_d[TW'(lnk_rd_q.succ)] = 1'b1;
          chg = 1'b1;
        end
        state_d = S_RCH_RD;
        if (last_link) begin
          lidx_d = '0;
          changed_d = 1'b0;
          if (!(changed_q || chg)) begin
            state_d = S_LNK_DONE;
          end
        end else begin
          lidx_d = lidx_q + LCW'(1);
          changed_d = changed_q || chg;
        end
      end
      S_LNK_DONE: begin
        state_d = S_RESP;
        if (dup_q) begin
          res_status_d = ST_DUP;
        end else if (visited_q[TW'(pred_q)]) begin
          res_status_d = ST_CYCLE;
        end else begin
          lnk_we = 1'b1;
          res_idx_d = IDX_W'(link_count_q);
          link_count_d = link_count_q + LCW'(1);
        end
      end
      S_CON_RD: begin
        lnk_re = 1'b1;
        state_d = S_CON_EX;
      end
      S_CON_EX: begin
        if (visited_q[TW'(lnk_rd_q.pred)] != visited_q[TW'(lnk_rd_q.succ)]) begin
          visited_d[TW'(lnk_rd_q.pred)] = 1'b1;
          visited_d[TW'(lnk_rd_q.succ)] = 1'b1;
          chg = 1'b1;
        end
        state_d = S_CON_RD;
        if (last_link) begin
          lidx_d = '0;
          changed_d = 1'b0;
          if (!(changed_q || chg)) begin
            state_d = S_CON_CHK;
          end
        end else begin
          lidx_d = lidx_q + LCW'(1);
          changed_d = changed_q || chg;
        end
      end
      S_CON_CHK: begin
        tidx_d = '0;
        if (conn_ok) begin
          state_d = S_DEG_CLR;
        end else begin
          res_status_d = ST_DISC;
          res_idx_d = '0;
          state_d = S_RESP;
        end
      end
      S_DEG_CLR: begin
        if (tidx_q == task_count_q) begin
          lidx_d = '0;
          tidx_d = '0;
          tail_d = '0;
          state_d = (link_count_q == '0) ? S_SRC_RD : S_CNT_RD;
        end else begin
          deg_we = 1'b1;
          deg_waddr = tidx_q[TW-1:0];
          tidx_d = tidx_q + CW'(1);
        end
      end
      S_CNT_RD: begin
        lnk_re = 1'b1;
        state_d = S_CNT_DG;
      end
      S_CNT_DG: begin
        deg_re = 1'b1;
        state_d = S_CNT_WR;
      end
      S_CNT_WR: begin
        deg_we = 1'b1;
        deg_wdata = deg_rd_q + DEG_W'(1);
        lidx_d = lidx_q + LCW'(1);
        state_d = last_link ? S_SRC_RD : S_CNT_RD;
      end
      S_SRC_RD: begin
        if (tidx_q == task_count_q) begin
          head_d = '0;
          state_d = S_KHN_TOP;
        end else begin
          deg_re = 1'b1;
          deg_raddr = tidx_q[TW-1:0];
          state_d = S_SRC_EX;
        end
      end
      S_SRC_EX: begin
        if (deg_rd_q == '0) begin
          topo_we = 1'b1;
          topo_wdata = tidx_q[TW-1:0];
          tail_d = tail_q + CW'(1);
        end
        tidx_d = tidx_q + CW'(1);
        state_d = S_SRC_RD;
      end
      S_KHN_TOP: begin
        if (head_q == tail_q) begin
          tidx_d = '0;
          total_d = '0;
          state_d = S_FWD_TOP;
        end else begin
          topo_re = 1'b1;
          topo_raddr = head_q[TW-1:0];
          state_d = S_KHN_NODE;
        end
      end
      S_KHN_NODE: begin
        node_d = topo_rd_q;
        head_d = head_q + CW'(1);
        lidx_d = '0;
        state_d = (link_count_q == '0) ? S_KHN_TOP : S_KHN_RD;
      end
      S_KHN_RD: begin
        lnk_re = 1'b1;
        state_d = S_KHN_EX;
      end
      S_KHN_EX: begin
        if (7'(lnk_rd_q.pred) == 7'(node_q)) begin
          deg_re = 1'b1;
          state_d = S_KHN_DG;
        end else begin
          lidx_d = lidx_q + LCW'(1);
          state_d = last_link ? S_KHN_TOP : S_KHN_RD;
        end
      end
      S_KHN_DG: begin
        if (deg_rd_q != '0) begin
          deg_we = 1'b1;
          deg_wdata = deg_rd_q - DEG_W'(1);
          if (deg_rd_q == DEG_W'(1) && tail_q < CW'(MAX_TASKS)) begin
            topo_we = 1'b1;
            tail_d = tail_q + CW'(1);
          end
        end
        lidx_d = lidx_q + LCW'(1);
        state_d = last_link ? S_KHN_TOP : S_KHN_RD;
      end
      S_FWD_TOP: begin
        if (tidx_q == tail_q) begin
          state_d = S_BWD_TOP;
        end else begin
          topo_re = 1'b1;
          state_d = S_FWD_NODE;
        end
      end
      S_FWD_NODE: begin
        node_d = topo_rd_q;
        dur_re = 1'b1;
        state_d = S_FWD_INIT;
      end
      S_FWD_INIT: begin
        acc_d = '0;
        lidx_d = '0;
        state_d = (link_count_q == '0) ? S_FWD_WR : S_FWD_RD;
      end
      S_FWD_RD: begin
        lnk_re = 1'b1;
        state_d = S_FWD_EX;
      end
      S_FWD_EX: begin
        if (7'(lnk_rd_q.succ) == 7'(node_q)) begin
          tim_re = 1'b1;
          tim_raddr = TW'(lnk_rd_q.pred);
          state_d = S_FWD_CAND;
        end else begin
          lidx_d = lidx_q + LCW'(1);
          state_d = last_link ? S_FWD_WR : S_FWD_RD;
        end
      end
      S_FWD_CAND: begin
        if (alu_better) begin
          acc_d = alu_cand;
        end
        lidx_d = lidx_q + LCW'(1);
        state_d = last_link ? S_FWD_WR : S_FWD_RD;
      end
      S_FWD_WR: begin
        acc_d = ACC_W'(sat_time(acc_q));
        state_d = S_FWD_WR2;
      end
      S_FWD_WR2: begin
        fwd_we = 1'b1;
        if (ef_new > total_q) begin
          total_d = ef_new;
        end
        tidx_d = tidx_q + CW'(1);
        state_d = S_FWD_TOP;
      end
      S_BWD_TOP: begin
        if (tidx_q == '0) begin
          state_d = S_ROW_TOP;
        end else begin
          topo_re = 1'b1;
          topo_raddr = tidx_m1[TW-1:0];
          state_d = S_BWD_NODE;
        end
      end
      S_BWD_NODE: begin
        node_d = topo_rd_q;
        dur_re = 1'b1;
        state_d = S_BWD_INIT;
      end
      S_BWD_INIT: begin
        acc_d = ACC_W'(total_q);
        any_d = 1'b0;
        lidx_d = '0;
        state_d = (link_count_q == '0) ? S_BWD_WR : S_BWD_RD;
      end
      S_BWD_RD: begin
        lnk_re = 1'b1;
        state_d = S_BWD_EX;
      end
      S_BWD_EX: begin
        if (7'(lnk_rd_q.pred) == 7'(node_q)) begin
          tim_re = 1'b1;
          tim_raddr = TW'(lnk_rd_q.succ);
          state_d = S_BWD_CAND;
        end else begin
          lidx_d = lidx_q + LCW'(1);
          state_d = last_link ? S_BWD_WR : S_BWD_RD;
        end
      end
      S_BWD_CAND: begin
        if (alu_better) begin
          acc_d = alu_cand;
        end
        any_d = 1'b1;
        lidx_d = lidx_q + LCW'(1);
        state_d = last_link ? S_BWD_WR : S_BWD_RD;
      end
      S_BWD_WR: begin
        acc_d = ACC_W'(sat_time(acc_q));
        state_d = S_BWD_WR2;
      end
      S_BWD_WR2: begin
        bwd_we = 1'b1;
        wr_a = sat_time(acc_q - ACC_W'(dur_x));
        wr_b = acc_q[TIME_W-1:0];
        tidx_d = tidx_m1;
        state_d = S_BWD_TOP;
      end
      S_ROW_TOP: begin
        if (tidx_q == tail_q) begin
          state_d = S_SUM;
        end else begin
          topo_re = 1'b1;
          state_d = S_ROW_NODE;
        end
      end
      S_ROW_NODE: begin
        node_d = topo_rd_q;
        tim_re = 1'b1;
        state_d = S_ROW_OUT;
      end
      S_ROW_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_idx_d = IDX_W'(node_q);
          out_es_d = es_rd_q;
          out_ef_d = ef_rd_q;
          out_ls_d = ls_rd_q;
          out_lf_d = lf_rd_q;
          out_crit_d = (ef_rd_q == lf_rd_q);
          out_last_d = 1'b0;
          tidx_d = tidx_q + CW'(1);
          state_d = S_ROW_TOP;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_load = 1'b1;
          out_total_d = total_q[22:0];
          out_sum_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      task_count_q <= '0;
      link_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      task_count_q <= task_count_d;
      link_count_q <= link_count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tidx_q <= tidx_d;
    head_q <= head_d;
    tail_q <= tail_d;
    lidx_q <= lidx_d;
    node_q <= node_d;
    acc_q <= acc_d;
    total_q <= total_d;
    any_q <= any_d;
    changed_q <= changed_d;
    dup_q <= dup_d;
    visited_q <= visited_d;
    pred_q <= pred_d;
    succ_q <= succ_d;
    kind_q <= kind_d;
    lag_q <= lag_d;
    res_status_q <= res_status_d;
    res_idx_q <= res_idx_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_idx_q <= out_idx_d;
      out_es_q <= out_es_d;
      out_ef_q <= out_ef_d;
      out_ls_q <= out_ls_d;
      out_lf_q <= out_lf_d;
      out_crit_q <= out_crit_d;
      out_total_q <= out_total_d;
      out_sum_q <= out_sum_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[link_count_q[LW-1:0]] <= '{pred: pred_q, succ: succ_q, kind: kind_q, lag: lag_q};
    end
    if (lnk_re) begin
      lnk_rd_q <= lnk_mem[lidx_q[LW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dur_we) begin
      dur_mem[task_count_q[TW-1:0]] <= DW'(duration_i);
    end
    if (dur_re) begin
      dur_rd_q <= dur_mem[topo_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      es_mem[node_q] <= wr_a;
      ef_mem[node_q] <= wr_b;
    end
    if (bwd_we) begin
      ls_mem[node_q] <= wr_a;
      lf_mem[node_q] <= wr_b;
    end
    if (tim_re) begin
      es_rd_q <= es_mem[tim_raddr];
      ef_rd_q <= ef_mem[tim_raddr];
      ls_rd_q <= ls_mem[tim_raddr];
      lf_rd_q <= lf_mem[tim_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rd_q <= deg_mem[deg_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (topo_we) begin
      topo_mem[topo_waddr] <= topo_wdata;
    end
    if (topo_re) begin
      topo_rd_q <= topo_mem[topo_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_index_o    = out_idx_q;
  assign early_start_o    = out_es_q;
  assign early_finish_o   = out_ef_q;
  assign late_start_o     = out_ls_q;
  assign late_finish_o    = out_lf_q;
  assign is_critical_o    = out_crit_q;
  assign total_duration_o = out_total_q;
  assign is_summary_o     = out_sum_q;
  assign last_o           = out_last_q;

  `CPS_ASSERT_IMP(a_task_count_range, clk_i, rst_ni, 1'b1, task_count_q <= CW'(MAX_TASKS))
  `CPS_ASSERT_IMP(a_link_count_range, clk_i, rst_ni, 1'b1, link_count_q <= LCW'(MAX_LINKS))
  `CPS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CPS_ASSERT_IMP(a_summary_is_last, clk_i, rst_ni, out_valid_o && is_summary_o, last_o)

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// Critical path scheduler testbench
// Drives clear, add task, add link and compute commands into the scheduler
// core and checks every result row against a predictor of the task store,
// link checks, FIFO topological order and forward and backward passes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cps_pkg::*;

  localparam int NTASK = 32;
  localparam int NLINK = 64;
  localparam longint TMAXV = 8388607;
  localparam longint TMINV = -8388608;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry;
    logic signed [23:0] es, ef, ls, lf;
    logic               crit;
    logic [22:0]        total;
    logic               summ;
    logic               last;
  } row_t;

  class schedule_board;
    row_t              rows_due[$];
    int                errors;
    logic [15:0]       dur[NTASK];
    int                n_tasks;
    int                n_links;
    logic [4:0]        lp[NLINK];
    logic [4:0]        ls_[NLINK];
    logic [1:0]        lk[NLINK];
    longint            lg[NLINK];
    longint            es[NTASK], ef[NTASK], lst[NTASK], lfn[NTASK];

    function longint clip(longint v);
      if (v > TMAXV) return TMAXV;
      if (v < TMINV) return TMINV;
      return v;
    endfunction

    function void push_row(logic [2:0] st, int idx, longint a, longint b, longint c,
                           longint d, bit cr, longint tot, bit sm, bit lt);
      row_t r;
      r.status = st; r.entry = idx[5:0];
      r.es = a[23:0]; r.ef = b[23:0]; r.ls = c[23:0]; r.lf = d[23:0];
      r.crit = cr; r.total = tot[22:0]; r.summ = sm; r.last = lt;
      rows_due = {rows_due, r};
    endfunction

    function bit path_exists(int from, int to);
      bit seen[NTASK];
      bit changed;
      foreach (seen[i]) seen[i] = 0;
      seen[from] = 1;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int i = 0; i < n_links; i++) begin
          if (seen[lp[i]] && !seen[ls_[i]]) begin
            seen[ls_[i]] = 1;
            changed = 1;
          end
        end
      end
      return seen[to];
    endfunction

    function bit linked_up();
      bit seen[NTASK];
      bit changed;
      int cnt;
      if (n_tasks <= 1) return 1;
      foreach (seen[i]) seen[i] = 0;
      seen[0] = 1;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int i = 0; i < n_links; i++) begin
          if (seen[lp[i]] != seen[ls_[i]]) begin
            seen[lp[i]] = 1; seen[ls_[i]] = 1; changed = 1;
          end
        end
      end
      cnt = 0;
      for (int i = 0; i < n_tasks; i++) cnt += seen[i];
      return cnt == n_tasks;
    endfunction

    function void run_schedule();
      int deg[NTASK];
      int order[NTASK];
      int head, tail, t, s;
      longint d, start, c, total, fin;
      bit any;
      if (!linked_up()) begin
        push_row(ST_DISC, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < NTASK; i++) deg[i] = 0;
      for (int i = 0; i < n_links; i++) deg[ls_[i]]++;
      head = 0; tail = 0;
      for (int i = 0; i < n_tasks; i++) if (deg[i] == 0) order[tail++] = i;
      while (head < tail) begin
        t = order[head++];
        for (int i = 0; i < n_links; i++) begin
          if (lp[i] != t) continue;
          s = ls_[i];
          if (deg[s] > 0) begin
            deg[s]--;
            if (deg[s] == 0 && tail < NTASK) order[tail++] = s;
          end
        end
      end
      total = 0;
      for (int k = 0; k < tail; k++) begin
        t = order[k]; d = dur[t]; start = 0;
        for (int i = 0; i < n_links; i++) begin
          if (ls_[i] != t) continue;
          case (lk[i])
            2'd0: c = ef[lp[i]] + lg[i];
            2'd1: c = es[lp[i]] + lg[i];
            2'd2: c = ef[lp[i]] + lg[i] - d;
            default: c = es[lp[i]] + lg[i] - d;
          endcase
          if (c > start) start = c;
        end
        es[t] = clip(start);
        ef[t] = clip(es[t] + d);
        if (ef[t] > total) total = ef[t];
      end
      for (int k = tail - 1; k >= 0; k--) begin
        t = order[k]; d = dur[t]; fin = total; any = 0;
        for (int i = 0; i < n_links; i++) begin
          if (lp[i] != t) continue;
          case (lk[i])
            2'd0: c = lst[ls_[i]] - lg[i];
            2'd1: c = lst[ls_[i]] - lg[i] + d;
            2'd2: c = lfn[ls_[i]] - lg[i];
            default: c = lfn[ls_[i]] - lg[i] + d;
          endcase
          if (!any || c < fin) fin = c;
          any = 1;
        end
        lfn[t] = clip(fin);
        lst[t] = clip(lfn[t] - d);
      end
      for (int k = 0; k < tail; k++) begin
        t = order[k];
        push_row(ST_OK, t, es[t], ef[t], lst[t], lfn[t], ef[t] == lfn[t], 0, 0, 0);
      end
      if (total > TMAXV) total = TMAXV;
      push_row(ST_OK, 0, 0, 0, 0, 0, 0, total, 1, 1);
    endfunction

    function void note_command(cmd_e cmd, logic [15:0] du, logic [4:0] p,
                               logic [4:0] s, logic [1:0] kind, logic signed [15:0] lag);
      logic [2:0] st;
      case (cmd)
        CMD_CLEAR: begin
          n_tasks = 0; n_links = 0;
          push_row(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        end
        CMD_TASK: begin
          if (n_tasks >= NTASK) push_row(ST_TFULL, 0, 0, 0, 0, 0, 0, 0, 0, 1);
          else begin
            dur[n_tasks] = du;
            push_row(ST_OK, n_tasks, 0, 0, 0, 0, 0, 0, 0, 1);
            n_tasks++;
          end
        end
        CMD_LINK: begin
          st = ST_OK;
          if (n_links >= NLINK) st = ST_LFULL;
          else if (p >= n_tasks || s >= n_tasks) st = ST_BADIDX;
          else if (p == s) st = ST_SELF;
          else begin
            for (int i = 0; i < n_links; i++)
              if (lp[i] == p && ls_[i] == s) st = ST_DUP;
            if (st == ST_OK && path_exists(s, p)) st = ST_CYCLE;
          end
          if (st != ST_OK) push_row(st, 0, 0, 0, 0, 0, 0, 0, 0, 1);
          else begin
            lp[n_links] = p; ls_[n_links] = s; lk[n_links] = kind; lg[n_links] = lag;
            push_row(ST_OK, n_links, 0, 0, 0, 0, 0, 0, 0, 1);
            n_links++;
          end
        end
        default: run_schedule();
      endcase
    endfunction

    function void check_row(row_t got);
      row_t w;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d entry %0d", $time, got.status,
                 got.entry);
        errors++;
        return;
      end
      w = rows_due.pop_front();
      if (got !== w) begin
        $display("%0t: mismatch expected st=%0d idx=%0d es=%0d ef=%0d ls=%0d lf=%0d",
                 $time, w.status, w.entry, w.es, w.ef, w.ls, w.lf,
                 " c=%0d tot=%0d sm=%0d l=%0d", w.crit, w.total, w.summ, w.last);
        $display("%0t: mismatch actual   st=%0d idx=%0d es=%0d ef=%0d ls=%0d lf=%0d",
                 $time, got.status, got.entry, got.es, got.ef, got.ls, got.lf,
                 " c=%0d tot=%0d sm=%0d l=%0d", got.crit, got.total, got.summ, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic [1:0] cmd_i = 0, link_kind_i = 0;
  logic [15:0] duration_i = 0;
  logic [4:0] pred_index_i = 0, succ_index_i = 0;
  logic signed [15:0] lag_i = 0;
  logic [2:0] status_o;
  logic [5:0] entry_index_o;
  logic signed [23:0] early_start_o, early_finish_o, late_start_o, late_finish_o;
  logic is_critical_o, is_summary_o, last_o;
  logic [22:0] total_duration_o;

  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;
  schedule_board board = new();

  critical_path_scheduler_core uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    row_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.status = status_o; r.entry = entry_index_o;
      r.es = early_start_o; r.ef = early_finish_o;
      r.ls = late_start_o; r.lf = late_finish_o;
      r.crit = is_critical_o; r.total = total_duration_o;
      r.summ = is_summary_o; r.last = last_o;
      board.check_row(r);
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  task automatic send_cmd(cmd_e cmd, logic [15:0] du = 0, logic [4:0] p = 0,
                          logic [4:0] s = 0, logic [1:0] kind = 0,
                          logic signed [15:0] lag = 0);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    cmd_i <= cmd; duration_i <= du; pred_index_i <= p; succ_index_i <= s;
    link_kind_i <= kind; lag_i <= lag; in_valid_i <= 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_command(cmd, du, p, s, kind, lag);
    @(negedge clk_i);
  endtask

  task automatic random_project(int nt, int nl);
    logic [15:0] lag;
    send_cmd(CMD_CLEAR);
    for (int i = 0; i < nt; i++)
      send_cmd(CMD_TASK, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
    for (int i = 0; i < nl; i++) begin
      lag = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(10) - 5);
      if ($urandom_range(7) == 0)
        send_cmd(CMD_LINK, 0, 5'($urandom), 5'($urandom), 2'($urandom), lag);
      else
        send_cmd(CMD_LINK, 0, 5'($urandom_range(nt - 1)), 5'($urandom_range(nt - 1)),
                 2'($urandom), lag);
    end
    send_cmd(CMD_RUN);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    send_idle = 35; recv_idle = 87;
    send_cmd(CMD_RUN);
    send_cmd(CMD_TASK, 16'hFFFF);
    send_cmd(CMD_RUN);
    send_cmd(CMD_TASK, 16'd0);
    send_cmd(CMD_TASK, 16'd5);
    send_cmd(CMD_RUN);
    send_cmd(CMD_LINK, 0, 5'd0, 5'd0);
    send_cmd(CMD_LINK, 0, 5'd0, 5'd31);
    send_cmd(CMD_LINK, 0, 5'd0, 5'd1, 2'd0, 16'sh7FFF);
    send_cmd(CMD_LINK, 0, 5'd0, 5'd1, 2'd1);
    send_cmd(CMD_LINK, 0, 5'd1, 5'd2, 2'd1, -16'sd3);
    send_cmd(CMD_LINK, 0, 5'd2, 5'd0, 2'd2, 16'sh8000);
    send_cmd(CMD_LINK, 0, 5'd0, 5'd2, 2'd3, 16'sh8000);
    send_cmd(CMD_LINK, 0, 5'd2, 5'd1, 2'd2, 16'sd4);
    send_cmd(CMD_RUN);
    send_cmd(CMD_CLEAR);
    for (int i = 0; i < 33; i++) send_cmd(CMD_TASK, 16'hFFFF);
    for (int i = 0; i < 65; i++)
      send_cmd(CMD_LINK, 0, 5'(i % 31), 5'(i % 31 + 1), 2'(i), 16'sh7FFF);
    send_cmd(CMD_RUN);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 35 : (ph == 1) ? 87 : 0;
      recv_idle = (ph == 0) ? 87 : (ph == 1) ? 35 : 0;
      random_project($urandom_range(8, 2), $urandom_range(12, 1));
    end
    in_valid_i <= 0;
    while (board.rows_due.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (board.errors == 0 && board.rows_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
